// ===== src/tcp_pkg.sv =====
`default_nettype none
package tcp_pkg;

  // Telnet command bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_NOP  = 8'd241;
  localparam logic [7:0] B_BRK  = 8'd243;
  localparam logic [7:0] B_GA   = 8'd249;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_DONT = 8'd254;

  // Event codes
  localparam logic [3:0] EV_NONE   = 4'd0;
  localparam logic [3:0] EV_DATA   = 4'd1;
  localparam logic [3:0] EV_FILTER = 4'd2;
  localparam logic [3:0] EV_NOP    = 4'd3;
  localparam logic [3:0] EV_BRK    = 4'd4;
  localparam logic [3:0] EV_GA     = 4'd10;
  localparam logic [3:0] EV_OPTION = 4'd11;

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_IAC    = 3'd1,
    ST_OPT    = 3'd2,
    ST_SB     = 3'd3,
    ST_SB_IAC = 3'd4
  } parse_state_t;

  typedef struct packed {
    parse_state_t state;
    logic [1:0]   pending_verb;
    logic         seen;
  } ctx_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [7:0] data_byte;
    logic [1:0] option_verb;
    logic [7:0] option_code;
    logic       nvt_seen;
  } result_t;

endpackage
`default_nettype wire

// ===== src/tcp_if.sv =====
`default_nettype none
interface tcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tcp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_kind;
  logic [7:0] data_byte;
  logic [1:0] option_verb;
  logic [7:0] option_code;
  logic       nvt_seen;
  modport source (output valid, output event_kind, output data_byte, output option_verb,
                  output option_code, output nvt_seen, input ready);
  modport sink (input valid, input event_kind, input data_byte, input option_verb,
                input option_code, input nvt_seen, output ready);
endinterface

interface tcp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/tcp_decode.sv =====
`default_nettype none
module tcp_decode (
  input  wire tcp_pkg::ctx_t    ctx,
  input  wire logic [7:0]       filter_char,
  input  wire logic [7:0]       rx_byte,
  output tcp_pkg::ctx_t         ctx_nxt,
  output tcp_pkg::result_t      res
);

  always_comb begin
    ctx_nxt = ctx;
    res     = '0;
    case (ctx.state)
      tcp_pkg::ST_IAC: begin
        ctx_nxt.state = tcp_pkg::ST_DATA;
        case (rx_byte) inside
          tcp_pkg::B_IAC: begin
            res.event_kind = tcp_pkg::EV_DATA;
            res.data_byte  = tcp_pkg::B_IAC;
          end
          tcp_pkg::B_NOP: res.event_kind = tcp_pkg::EV_NOP;
          [tcp_pkg::B_BRK:tcp_pkg::B_GA]:
            res.event_kind = tcp_pkg::EV_BRK + 4'(rx_byte - tcp_pkg::B_BRK);
          tcp_pkg::B_SB: ctx_nxt.state = tcp_pkg::ST_SB;
          [tcp_pkg::B_WILL:tcp_pkg::B_DONT]: begin
            ctx_nxt.pending_verb = 2'(rx_byte - tcp_pkg::B_WILL);
            ctx_nxt.seen         = 1'b1;
            ctx_nxt.state        = tcp_pkg::ST_OPT;
          end
          default: ; // DM, stray SE and low codes are dropped
        endcase
      end
      tcp_pkg::ST_OPT: begin
        res.event_kind  = tcp_pkg::EV_OPTION;
        res.option_verb = ctx.pending_verb;
        res.option_code = rx_byte;
        ctx_nxt.state   = tcp_pkg::ST_DATA;
      end
      tcp_pkg::ST_SB: begin
        if (rx_byte == tcp_pkg::B_IAC) begin
          ctx_nxt.state = tcp_pkg::ST_SB_IAC;
        end
      end
      tcp_pkg::ST_SB_IAC: begin
        ctx_nxt.state = (rx_byte == tcp_pkg::B_SE) ? tcp_pkg::ST_DATA : tcp_pkg::ST_SB;
      end
      default: begin
        ctx_nxt.state = tcp_pkg::ST_DATA;
        // filter check wins over IAC
        if (filter_char != 8'd0 && rx_byte == filter_char) begin
          res.event_kind = tcp_pkg::EV_FILTER;
        end else if (rx_byte == tcp_pkg::B_IAC) begin
          ctx_nxt.state = tcp_pkg::ST_IAC;
        end else begin
          res.event_kind = tcp_pkg::EV_DATA;
          res.data_byte  = rx_byte;
        end
      end
    endcase
    res.nvt_seen = ctx_nxt.seen;
  end

endmodule
`default_nettype wire

// ===== src/telnet_command_parser_core.sv =====
// Telnet receive parser: takes one received byte per transfer on in_bus and
// gives exactly one result transfer on out_bus for it, in order. Throughput
// is one byte per clock while the sink does not stall. A taken byte is held
// in the input register, then passes through one state step of decode logic
// into the result register, from which it transfers on out_bus. The result
// register holds while the sink stalls and the input register keeps taking
// bytes until both are full.
// filter_char is written through cfg_bus (always ready); write it only while
// no byte is in flight. Reset clears filter_char, the parse state and the
// sticky negotiation flag.
`default_nettype none
module telnet_command_parser_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcp_in_if.sink     in_bus,
  tcp_out_if.source  out_bus,
  tcp_cfg_if.sink    cfg_bus
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // result register and parser context
  logic              out_valid_r;
  tcp_pkg::result_t  res_r;
  tcp_pkg::ctx_t     ctx_r;
  tcp_pkg::ctx_t     ctx_nxt;
  tcp_pkg::result_t  res_nxt;

  logic [7:0] filter_r;
  logic       advance;

  // result slot free or draining this cycle
  assign advance      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !in_valid_r || advance;
  assign cfg_bus.ready = 1'b1;

  tcp_decode u_decode (
    .ctx         (ctx_r),
    .filter_char (filter_r),
    .rx_byte     (in_byte_r),
    .ctx_nxt     (ctx_nxt),
    .res         (res_nxt)
  );

  // filter character register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= 8'd0;
    end else if (cfg_bus.valid) begin
      filter_r <= cfg_bus.data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_byte_r <= in_bus.rx_byte;
    end
  end

  // result stage; context advances only when a byte moves into the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ctx_r       <= '{state: tcp_pkg::ST_DATA, pending_verb: 2'd0, seen: 1'b0};
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        ctx_r <= ctx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.event_kind  = res_r.event_kind;
  assign out_bus.data_byte   = res_r.data_byte;
  assign out_bus.option_verb = res_r.option_verb;
  assign out_bus.option_code = res_r.option_code;
  assign out_bus.nvt_seen    = res_r.nvt_seen;

endmodule
`default_nettype wire

// ===== src/tcp_checker.sv =====
`default_nettype none
module tcp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] event_kind,
  input wire logic [7:0] data_byte,
  input wire logic [1:0] option_verb,
  input wire logic [7:0] option_code,
  input wire logic       nvt_seen
);

  // stalled result holds its event kind, data byte and option code
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(data_byte)
      && $stable(option_code))
    else $error("result changed while stalled");

  // negotiation flag is sticky
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    nvt_seen |=> nvt_seen)
    else $error("nvt_seen dropped");

  // an option event implies negotiation has been seen
  a_opt_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == tcp_pkg::EV_OPTION |-> nvt_seen)
    else $error("option event without nvt_seen");

  // unused payload fields are zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind != tcp_pkg::EV_OPTION |-> option_verb == 2'd0
      && option_code == 8'd0 && (event_kind == tcp_pkg::EV_DATA || data_byte == 8'd0))
    else $error("stray payload bits");

endmodule

bind telnet_command_parser_core tcp_checker u_tcp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .event_kind  (out_bus.event_kind),
  .data_byte   (out_bus.data_byte),
  .option_verb (out_bus.option_verb),
  .option_code (out_bus.option_code),
  .nvt_seen    (out_bus.nvt_seen)
);
`default_nettype wire
